// ===== src/dfm_pkg.sv =====
// ----------------------------------------------------------------------------
// dfm_pkg
// Types, constants and helpers for the dielectric Fresnel mirror.
// ----------------------------------------------------------------------------
package dfm_pkg;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [23:0] REFL_MAX    = 24'hFF_FFFF;
	localparam logic [23:0] REFL_ONE    = 24'h01_0000;
	localparam logic [16:0] DENSITY_ONE = 17'h1_0000;
	localparam logic [15:0] ETA_RESET   = 16'd4096;

	localparam logic REG_ETA_I = 1'b0;
	localparam logic REG_ETA_T = 1'b1;

	typedef struct packed {
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic [15:0] absz;
		logic [15:0] ei;
		logic [15:0] et;
		logic [30:0] c30;
		logic        tir;
		logic        zperp;
		logic        zpar;
		logic        over;
	} side_t;

	function automatic logic [15:0] neg_sat16(input logic [15:0] v);
		logic [15:0] r;
		if (v == 16'h8000) begin
			r = 16'h7FFF;
		end else begin
			r = 16'(~v + 16'd1);
		end
		return r;
	endfunction

endpackage

// ===== src/dielectric_fresnel_mirror.sv =====
// ----------------------------------------------------------------------------
// dielectric_fresnel_mirror
// Mirrors a shading-space direction about the normal and computes the
// unpolarized dielectric Fresnel reflectance divided by the cosine.
// Throughput is one word per cycle while the output is not stalled; square
// roots and divisions are unrolled into one-bit-per-stage pipelines, so
// nothing in the datapath iterates.
// A stall at the output holds the whole pipeline in place.
// Reset clears all valid bits and sets both indices to the same value, 4096.
// ----------------------------------------------------------------------------
module dielectric_fresnel_mirror import dfm_pkg::*; #(
	parameter int DIR_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// out_dir_x, out_dir_y, out_dir_z
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// in_dir_x, in_dir_y, in_dir_z, reflectance, density, zero padding
	output logic [95:0] m_tdata,
	// saturated
	output logic [0:0]  m_tuser
);

	localparam int CSH = 30 - DIR_FRAC_BITS;
	localparam int CW  = 16 + CSH;
	localparam int NSH = 44 - DIR_FRAC_BITS;
	localparam int NW  = 62 - NSH;
	localparam int SQN = 31;
	localparam int D1N = 31;
	localparam int RTN = 30;
	localparam int D2N = 24;
	localparam int LAT = 3 + SQN + 2 + D1N + 2 + SQN + 2 + RTN + 3 + D2N + 1;

	logic adv;
	logic [15:0] eta_i_q, eta_t_q;
	logic [LAT:1] vld_s;

	assign pready = 1'b1;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_i_q <= ETA_RESET;
			eta_t_q <= ETA_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_ETA_I: eta_i_q <= pwdata[15:0];
				REG_ETA_T: eta_t_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ETA_I: prdata = {16'd0, eta_i_q};
			REG_ETA_T: prdata = {16'd0, eta_t_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// Stage 1: mirror, index selection, cosine in Q30.
	logic [15:0] zraw, absz_in;
	logic        swap;
	logic [CW-1:0] cshift;
	logic [30:0] c30_in;
	side_t side_s1;

	assign zraw = s_tdata[47:32];
	assign absz_in = zraw[15] ? 16'(~zraw + 16'd1) : zraw;
	assign swap = zraw[15] || (zraw == 16'd0);
	assign cshift = CW'(absz_in) << CSH;
	assign c30_in = (64'(cshift) > 64'(Q30_ONE)) ? Q30_ONE : 31'(cshift);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.dx    <= neg_sat16(s_tdata[15:0]);
			side_s1.dy    <= neg_sat16(s_tdata[31:16]);
			side_s1.dz    <= zraw;
			side_s1.absz  <= absz_in;
			side_s1.ei    <= swap ? eta_t_q : eta_i_q;
			side_s1.et    <= swap ? eta_i_q : eta_t_q;
			side_s1.c30   <= c30_in;
			side_s1.tir   <= 1'b0;
			side_s1.zperp <= 1'b0;
			side_s1.zpar  <= 1'b0;
			side_s1.over  <= 1'b0;
		end
	end

	// Stages 2 and 3: one minus cosine squared.
	logic [61:0] csq_s2;
	side_t side_s2;
	logic [30:0] omc_s3;
	side_t side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			csq_s2  <= 62'(side_s1.c30) * 62'(side_s1.c30);
			side_s2 <= side_s1;
			omc_s3  <= 31'(32'(Q30_ONE) - csq_s2[61:30]);
			side_s3 <= side_s2;
		end
	end

	// Incident sine by square root, one result bit per stage.
	logic [60:0] sa_v_s [0:SQN];
	logic [62:0] sa_r_s [0:SQN];
	side_t       sa_side_s [0:SQN];

	assign sa_v_s[0] = {omc_s3, 30'd0};
	assign sa_r_s[0] = '0;
	assign sa_side_s[0] = side_s3;

	for (genvar k = 0; k < SQN; k++) begin : g_sqa
		localparam logic [62:0] BIT = 63'(1) << (60 - 2 * k);
		logic [62:0] trial;
		logic        ge;
		assign trial = sa_r_s[k] + BIT;
		assign ge = 63'(sa_v_s[k]) >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				sa_v_s[k+1]    <= ge ? 61'(63'(sa_v_s[k]) - trial) : sa_v_s[k];
				sa_r_s[k+1]    <= ge ? (sa_r_s[k] >> 1) + BIT : sa_r_s[k] >> 1;
				sa_side_s[k+1] <= sa_side_s[k];
			end
		end
	end

	// Snell product and total internal reflection test.
	logic [46:0] prod_s;
	side_t side_m_s;
	side_t d1_side_in;
	logic [16:0] d1_rem_s [0:D1N];
	logic [30:0] d1_lo_s  [0:D1N];
	logic [30:0] d1_q_s   [0:D1N];
	side_t       d1_side_s [0:D1N];

	always_comb begin
		d1_side_in = side_m_s;
		d1_side_in.tir = (side_m_s.et == 16'd0) ||
			(prod_s > 47'({side_m_s.et, 30'd0}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s   <= 47'(sa_side_s[SQN].ei) * 47'(sa_r_s[SQN][30:0]);
			side_m_s <= sa_side_s[SQN];
			d1_rem_s[0]  <= 17'(prod_s[46:31]);
			d1_lo_s[0]   <= prod_s[30:0];
			d1_q_s[0]    <= '0;
			d1_side_s[0] <= d1_side_in;
		end
	end

	// Transmitted sine by restoring division, one quotient bit per stage.
	for (genvar k = 0; k < D1N; k++) begin : g_div1
		logic [16:0] t;
		logic        ge;
		assign t = {d1_rem_s[k][15:0], d1_lo_s[k][30]};
		assign ge = t >= {1'b0, d1_side_s[k].et};
		always_ff @(posedge clk) begin
			if (adv) begin
				d1_rem_s[k+1]  <= ge ? t - {1'b0, d1_side_s[k].et} : t;
				d1_lo_s[k+1]   <= d1_lo_s[k] << 1;
				d1_q_s[k+1]    <= {d1_q_s[k][29:0], ge};
				d1_side_s[k+1] <= d1_side_s[k];
			end
		end
	end

	// One minus transmitted sine squared.
	logic [61:0] sts_s;
	side_t side_t1_s;
	logic [30:0] omc2_s;
	side_t side_t2_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			sts_s     <= 62'(d1_q_s[D1N]) * 62'(d1_q_s[D1N]);
			side_t1_s <= d1_side_s[D1N];
			omc2_s    <= 31'(32'(Q30_ONE) - sts_s[61:30]);
			side_t2_s <= side_t1_s;
		end
	end

	// Transmitted cosine by square root.
	logic [60:0] sb_v_s [0:SQN];
	logic [62:0] sb_r_s [0:SQN];
	side_t       sb_side_s [0:SQN];

	assign sb_v_s[0] = {omc2_s, 30'd0};
	assign sb_r_s[0] = '0;
	assign sb_side_s[0] = side_t2_s;

	for (genvar k = 0; k < SQN; k++) begin : g_sqb
		localparam logic [62:0] BIT = 63'(1) << (60 - 2 * k);
		logic [62:0] trial;
		logic        ge;
		assign trial = sb_r_s[k] + BIT;
		assign ge = 63'(sb_v_s[k]) >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				sb_v_s[k+1]    <= ge ? 61'(63'(sb_v_s[k]) - trial) : sb_v_s[k];
				sb_r_s[k+1]    <= ge ? (sb_r_s[k] >> 1) + BIT : sb_r_s[k] >> 1;
				sb_side_s[k+1] <= sb_side_s[k];
			end
		end
	end

	// Fresnel numerators and denominators.
	logic [46:0] a_s, b_s, p_s, q_s;
	side_t side_f_s;
	logic [30:0] cos_t;

	assign cos_t = sb_r_s[SQN][30:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s <= 47'(sb_side_s[SQN].ei) * 47'(sb_side_s[SQN].c30);
			b_s <= 47'(sb_side_s[SQN].et) * 47'(cos_t);
			p_s <= 47'(sb_side_s[SQN].et) * 47'(sb_side_s[SQN].c30);
			q_s <= 47'(sb_side_s[SQN].ei) * 47'(cos_t);
			side_f_s <= sb_side_s[SQN];
		end
	end

	logic [48:0] rp_rem_s [0:RTN];
	logic [47:0] rp_den_s [0:RTN];
	logic [29:0] rp_q_s   [0:RTN];
	logic [48:0] ra_rem_s [0:RTN];
	logic [47:0] ra_den_s [0:RTN];
	logic [29:0] ra_q_s   [0:RTN];
	side_t       rt_side_s [0:RTN];
	logic [47:0] dperp, dpar;
	side_t       rt_side_in;

	assign dperp = 48'(a_s) + 48'(b_s);
	assign dpar  = 48'(p_s) + 48'(q_s);

	always_comb begin
		rt_side_in = side_f_s;
		rt_side_in.zperp = (dperp == 48'd0);
		rt_side_in.zpar  = (dpar == 48'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_rem_s[0] <= 49'((a_s >= b_s) ? a_s - b_s : b_s - a_s);
			rp_den_s[0] <= dperp;
			rp_q_s[0]   <= '0;
			ra_rem_s[0] <= 49'((p_s >= q_s) ? p_s - q_s : q_s - p_s);
			ra_den_s[0] <= dpar;
			ra_q_s[0]   <= '0;
			rt_side_s[0] <= rt_side_in;
		end
	end

	// Both reflection ratios in Q30, one bit per stage.
	for (genvar k = 0; k < RTN; k++) begin : g_ratio
		logic [48:0] tp, ta;
		logic        gp, ga;
		assign tp = rp_rem_s[k] << 1;
		assign ta = ra_rem_s[k] << 1;
		assign gp = tp >= 49'(rp_den_s[k]);
		assign ga = ta >= 49'(ra_den_s[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				rp_rem_s[k+1] <= gp ? tp - 49'(rp_den_s[k]) : tp;
				rp_den_s[k+1] <= rp_den_s[k];
				rp_q_s[k+1]   <= {rp_q_s[k][28:0], gp};
				ra_rem_s[k+1] <= ga ? ta - 49'(ra_den_s[k]) : ta;
				ra_den_s[k+1] <= ra_den_s[k];
				ra_q_s[k+1]   <= {ra_q_s[k][28:0], ga};
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// Mean of the squared ratios, scaled down for the final division.
	logic [30:0] rperp, rpar;
	logic [61:0] sp_s, sr_s;
	side_t side_q1_s;
	logic [NW-1:0] n_s;
	side_t side_q2_s;
	side_t d2_side_in;
	logic [16:0] d2_rem_s [0:D2N];
	logic [23:0] d2_lo_s  [0:D2N];
	logic [23:0] d2_q_s   [0:D2N];
	side_t       d2_side_s [0:D2N];

	assign rperp = rt_side_s[RTN].zperp ? Q30_ONE : {1'b0, rp_q_s[RTN]};
	assign rpar  = rt_side_s[RTN].zpar  ? Q30_ONE : {1'b0, ra_q_s[RTN]};

	always_comb begin
		d2_side_in = side_q2_s;
		d2_side_in.over = 64'(n_s) >= (64'(side_q2_s.absz) << 24);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s <= 62'(rperp) * 62'(rperp);
			sr_s <= 62'(rpar) * 62'(rpar);
			side_q1_s <= rt_side_s[RTN];
			n_s <= NW'((63'(sp_s) + 63'(sr_s)) >> (1 + NSH));
			side_q2_s <= side_q1_s;
			d2_rem_s[0]  <= 17'(n_s >> 24);
			d2_lo_s[0]   <= n_s[23:0];
			d2_q_s[0]    <= '0;
			d2_side_s[0] <= d2_side_in;
		end
	end

	// Division by the cosine, one quotient bit per stage.
	for (genvar k = 0; k < D2N; k++) begin : g_div2
		logic [16:0] t;
		logic        ge;
		assign t = {d2_rem_s[k][15:0], d2_lo_s[k][23]};
		assign ge = t >= {1'b0, d2_side_s[k].absz};
		always_ff @(posedge clk) begin
			if (adv) begin
				d2_rem_s[k+1]  <= ge ? t - {1'b0, d2_side_s[k].absz} : t;
				d2_lo_s[k+1]   <= d2_lo_s[k] << 1;
				d2_q_s[k+1]    <= {d2_q_s[k][22:0], ge};
				d2_side_s[k+1] <= d2_side_s[k];
			end
		end
	end

	// Output stage.
	side_t       fin;
	logic [47:0] dir_s;
	logic [23:0] refl_s;
	logic        sat_s;

	assign fin = d2_side_s[D2N];

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s <= {fin.dz, fin.dy, fin.dx};
			if (fin.tir) begin
				refl_s <= REFL_ONE;
				sat_s  <= 1'b0;
			end else if (fin.absz == 16'd0 || fin.over) begin
				refl_s <= REFL_MAX;
				sat_s  <= 1'b1;
			end else begin
				refl_s <= d2_q_s[D2N];
				sat_s  <= 1'b0;
			end
		end
	end

	assign m_tdata = {7'd0, DENSITY_ONE, refl_s, dir_s};
	assign m_tuser = sat_s;

endmodule
